>>> rtl/vbsp_pkg.sv
// -----------------------------------------------------------------------------
// vbsp_pkg
// Shared types and constants of the sound-container stream parser.
// -----------------------------------------------------------------------------
package vbsp_pkg;

  localparam int unsigned SigLen = 20;
  localparam logic [31:0] MinFileSize = 32'd26;
  localparam logic [31:0] RateNum = 32'd1000000;

  // Parse phases
  localparam logic [2:0] PhSig  = 3'd0;
  localparam logic [2:0] PhOff  = 3'd1;
  localparam logic [2:0] PhSeek = 3'd2;
  localparam logic [2:0] PhType = 3'd3;
  localparam logic [2:0] PhLen  = 3'd4;
  localparam logic [2:0] PhBody = 3'd5;
  localparam logic [2:0] PhStop = 3'd6;

  // Block types
  localparam logic [7:0] BlkEnd   = 8'd0;
  localparam logic [7:0] BlkSound = 8'd1;
  localparam logic [7:0] BlkCont  = 8'd2;
  localparam logic [7:0] BlkNew   = 8'd9;

  // Status codes
  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StSig    = 2'd1;
  localparam logic [1:0] StOffset = 2'd2;
  localparam logic [1:0] StNoData = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic step;        // an input byte is taken
    logic rep_start;   // begin the report arithmetic
    logic div_step;    // one restoring division step
    logic mul_step;    // register the byte-rate product
  } vbsp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic emit;        // the byte taken produces a sample transfer
    logic finish;      // the byte taken is the last of the file
    logic active;      // the byte is not ignored
    logic div_done;
  } vbsp_stat_t;

  function automatic logic [7:0] sig_byte(input logic [4:0] idx);
    logic [7:0] r;
    begin
      unique case (idx)
        5'd0: r = 8'h43;  5'd1: r = 8'h72;  5'd2: r = 8'h65;  5'd3: r = 8'h61;
        5'd4: r = 8'h74;  5'd5: r = 8'h69;  5'd6: r = 8'h76;  5'd7: r = 8'h65;
        5'd8: r = 8'h20;  5'd9: r = 8'h56;  5'd10: r = 8'h6F; 5'd11: r = 8'h69;
        5'd12: r = 8'h63; 5'd13: r = 8'h65; 5'd14: r = 8'h20; 5'd15: r = 8'h46;
        5'd16: r = 8'h69; 5'd17: r = 8'h6C; 5'd18: r = 8'h65; 5'd19: r = 8'h1A;
        default: r = 8'h00;
      endcase
      return r;
    end
  endfunction

endpackage

>>> rtl/voc_block_stream_parser_top.sv
// -----------------------------------------------------------------------------
// voc_block_stream_parser_top
// Streaming parser for a sound-container file with sample pass-through.
// -----------------------------------------------------------------------------
// The stream runs at one byte a cycle whenever the output register is free
// and the report is not under way; a sample transfer held in that register
// by a stall holds off the next byte. After the last byte the report is
// formed in order: 32 steps of the restoring divider that forms the rate of
// the old sound block, a state to see it finish, the byte-rate multiplier and
// the load of the report. No byte is taken in that time. Write file_size
// before streaming; after the report every byte is taken and ignored until
// reset.
module voc_block_stream_parser_top import vbsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  data_byte_o,
  output logic [31:0] sample_rate_o,
  output logic [7:0]  bits_per_sample_o,
  output logic [7:0]  channel_count_o,
  output logic [31:0] sample_byte_count_o,
  output logic [15:0] block_align_o,
  output logic [31:0] byte_rate_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  vbsp_cmd_t   cmd;
  vbsp_stat_t  stat;
  logic        kind, smp_ld;
  logic [7:0]  smp_q;
  logic [31:0] rate, count, brate;
  logic [7:0]  bits, chans;
  logic [15:0] align;
  logic [1:0]  status;

  vbsp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .out_kind_o(kind), .out_sample_ld_o(smp_ld), .stat_i(stat), .cmd_o(cmd)
  );

  vbsp_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .byte_in_i, .cmd_i(cmd),
    .stat_o(stat), .rate_o(rate), .bits_o(bits), .chans_o(chans),
    .count_o(count), .align_o(align), .byte_rate_o(brate), .status_o(status)
  );

  // Sample byte register
  always_ff @(posedge clk_i) begin
    if (smp_ld) smp_q <= byte_in_i;
  end

  // Report fields read zero on a sample transfer
  assign kind_o              = kind;
  assign data_byte_o         = kind ? 8'd0 : smp_q;
  assign sample_rate_o       = kind ? rate : '0;
  assign bits_per_sample_o   = kind ? bits : '0;
  assign channel_count_o     = kind ? chans : '0;
  assign sample_byte_count_o = kind ? count : '0;
  assign block_align_o       = kind ? align : '0;
  assign byte_rate_o         = kind ? brate : '0;
  assign status_o            = kind ? status : '0;
  assign last_o              = kind;

endmodule

>>> rtl/vbsp_datapath.sv
// -----------------------------------------------------------------------------
// vbsp_datapath
// Parse state, block walker, format registers and the report arithmetic.
// -----------------------------------------------------------------------------
module vbsp_datapath import vbsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic [7:0]  byte_in_i,
  input  vbsp_cmd_t   cmd_i,
  output vbsp_stat_t  stat_o,
  output logic [31:0] rate_o,
  output logic [7:0]  bits_o,
  output logic [7:0]  chans_o,
  output logic [31:0] count_o,
  output logic [15:0] align_o,
  output logic [31:0] byte_rate_o,
  output logic [1:0]  status_o
);

  logic [31:0] file_size_q;
  logic [31:0] pos_q, pos_d;
  logic [2:0]  phase_q, phase_d;
  logic [15:0] offset_q, offset_d;
  logic [7:0]  kind_q, kind_d;
  logic [23:0] len_q, len_d;
  logic [23:0] idx_q, idx_d;
  logic        acc_q, acc_d;
  logic [31:0] gather_q, gather_d;
  logic        fmt_q, fmt_d;
  logic [31:0] rod_q, rod_d;
  logic        divm_q, divm_d;
  logic [7:0]  bits_q, bits_d;
  logic [7:0]  chans_q, chans_d;
  logic [31:0] count_q, count_d;
  logic [1:0]  err_q, err_d;
  logic        done_q, done_d;
  logic [31:0] held_q, held_d;

  logic        emit;
  logic [31:0] pos_inc;
  logic [15:0] off_full;
  logic [23:0] len_new;
  logic [23:0] idx_inc;
  logic [31:0] gath_or;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= '0;
    end else if (cfg_we_i) begin
      file_size_q <= cfg_wdata_i;
    end
  end

  assign pos_inc  = pos_q + 32'd1;
  assign off_full = {byte_in_i, offset_q[7:0]};
  assign len_new  = len_q | ({16'd0, byte_in_i} << {idx_q[1:0], 3'b000});
  assign idx_inc  = idx_q + 24'd1;
  assign gath_or  = gather_q | ({24'd0, byte_in_i} << {idx_q[1:0], 3'b000});

  // Block walker: next state for one byte
  always_comb begin
    pos_d = pos_q;  phase_d = phase_q;  offset_d = offset_q;  kind_d = kind_q;
    len_d = len_q;  idx_d = idx_q;  acc_d = acc_q;  gather_d = gather_q;
    fmt_d = fmt_q;  rod_d = rod_q;  divm_d = divm_q;  bits_d = bits_q;
    chans_d = chans_q;  count_d = count_q;  err_d = err_q;  done_d = done_q;
    held_d = held_q;  emit = 1'b0;
    if (!done_q && file_size_q != 32'd0) begin
      unique case (phase_q)
        PhSig: begin
          // pos stays below 20 here, so the low five bits index the signature
          if (byte_in_i != sig_byte(pos_q[4:0])) begin
            err_d = StSig;  phase_d = PhStop;
          end else if (pos_q >= 32'd19) begin
            phase_d = PhOff;
          end
        end
        PhOff: begin
          if (pos_q == 32'd20) begin
            offset_d = {8'd0, byte_in_i};
          end else begin
            offset_d = off_full;
            if (off_full < 16'd26 || {16'd0, off_full} > file_size_q) begin
              err_d = StOffset;  phase_d = PhStop;
            end else begin
              phase_d = PhSeek;
            end
          end
        end
        PhSeek, PhType: begin
          if (phase_q == PhType || pos_q == {16'd0, offset_q}) begin
            if (byte_in_i == BlkEnd || ({1'b0, pos_q} + 33'd4) > {1'b0, file_size_q}) begin
              phase_d = PhStop;
            end else begin
              kind_d = byte_in_i;  len_d = '0;  idx_d = '0;  acc_d = 1'b0;
              phase_d = PhLen;
            end
          end
        end
        PhLen: begin
          len_d = len_new;  idx_d = idx_inc;
          if (idx_inc >= 24'd3) begin
            if (({1'b0, pos_q} + 33'd1 + {9'd0, len_new}) > {1'b0, file_size_q}) begin
              phase_d = PhStop;
            end else begin
              idx_d = '0;  acc_d = (kind_q == BlkCont);
              phase_d = (len_new == 24'd0) ? PhType : PhBody;
            end
          end
        end
        PhBody: begin
          if (kind_q == BlkSound && len_q >= 24'd2) begin
            if (idx_q == 24'd0) begin
              gather_d = {24'd0, byte_in_i};
            end else if (idx_q == 24'd1) begin
              if (byte_in_i == 8'd0) begin
                acc_d = 1'b1;
                if (!fmt_q) begin
                  rod_d = gather_q;  divm_d = 1'b1;  bits_d = 8'd8;
                  chans_d = 8'd1;  fmt_d = 1'b1;
                end
              end
            end else begin
              emit = acc_q;
            end
          end else if (kind_q == BlkCont) begin
            emit = 1'b1;
          end else if (kind_q == BlkNew && len_q >= 24'd12) begin
            if (idx_q < 24'd8) begin
              if (idx_q == 24'd0 || idx_q == 24'd4) gather_d = {24'd0, byte_in_i};
              else gather_d = gath_or;
              if (idx_q == 24'd3) held_d = gath_or;
              if (idx_q == 24'd7 && gath_or[31:16] == 16'd0) begin
                acc_d = 1'b1;
                if (!fmt_q) begin
                  rod_d = held_q;  divm_d = 1'b0;  bits_d = gath_or[7:0];
                  chans_d = gath_or[15:8];  fmt_d = 1'b1;
                end
              end
            end else if (idx_q >= 24'd12) begin
              emit = acc_q;
            end
          end
          if (emit) count_d = count_q + 32'd1;
          idx_d = idx_inc;
          if (idx_inc >= len_q) phase_d = PhType;
        end
        default: ;
      endcase
      pos_d = pos_inc;
      if (pos_inc >= file_size_q) done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;  phase_q <= PhSig;  offset_q <= '0;  kind_q <= '0;
      len_q <= '0;  idx_q <= '0;  acc_q <= 1'b0;  gather_q <= '0;
      fmt_q <= 1'b0;  rod_q <= '0;  divm_q <= 1'b0;  bits_q <= 8'd8;
      chans_q <= 8'd1;  count_q <= '0;  err_q <= '0;  done_q <= 1'b0;
      held_q <= '0;
    end else if (cmd_i.step) begin
      pos_q <= pos_d;  phase_q <= phase_d;  offset_q <= offset_d;  kind_q <= kind_d;
      len_q <= len_d;  idx_q <= idx_d;  acc_q <= acc_d;  gather_q <= gather_d;
      fmt_q <= fmt_d;  rod_q <= rod_d;  divm_q <= divm_d;  bits_q <= bits_d;
      chans_q <= chans_d;  count_q <= count_d;  err_q <= err_d;  done_q <= done_d;
      held_q <= held_d;
    end
  end

  assign stat_o.emit   = emit;
  assign stat_o.active = !done_q && file_size_q != 32'd0;
  assign stat_o.finish = stat_o.active && (pos_inc >= file_size_q);

  // Report arithmetic: restoring divider, one quotient bit a cycle
  logic [31:0] quo_q, quo_d;
  logic [8:0]  rem_q, rem_d;
  logic [8:0]  den;
  logic [4:0]  dcnt_q;
  logic        dbusy_q;
  logic [9:0]  trial;
  logic [31:0] rate;
  logic [15:0] align;
  logic [31:0] brate_q;

  assign den   = 9'd256 - {1'b0, rod_q[7:0]};
  assign trial = {rem_q, RateNum[5'd31 - dcnt_q]};
  always_comb begin
    rem_d = trial[8:0];
    quo_d = quo_q;
    if (trial >= {1'b0, den}) begin
      rem_d = 9'(trial - {1'b0, den});
      quo_d[5'd31 - dcnt_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;  dcnt_q <= '0;
    end else if (cmd_i.rep_start) begin
      dbusy_q <= 1'b1;  dcnt_q <= '0;
    end else if (cmd_i.div_step && dbusy_q) begin
      dcnt_q <= dcnt_q + 5'd1;
      if (dcnt_q == 5'd31) dbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rep_start) begin
      quo_q <= '0;  rem_q <= '0;
    end else if (cmd_i.div_step && dbusy_q) begin
      quo_q <= quo_d;  rem_q <= rem_d;
    end
    if (cmd_i.mul_step) brate_q <= 32'(rate * {16'd0, align});
  end

  assign stat_o.div_done = !dbusy_q;
  assign rate  = divm_q ? quo_q : rod_q;
  assign align = 16'({8'd0, chans_q} * {11'd0, bits_q[7:3]});

  assign rate_o      = rate;
  assign bits_o      = bits_q;
  assign chans_o     = chans_q;
  assign count_o     = count_q;
  assign align_o     = align;
  assign byte_rate_o = brate_q;
  always_comb begin
    priority if (file_size_q < MinFileSize) status_o = StSig;
    else if (err_q != StOk) status_o = err_q;
    else if (!fmt_q || count_q == 32'd0) status_o = StNoData;
    else status_o = StOk;
  end

endmodule

>>> rtl/vbsp_ctrl.sv
// -----------------------------------------------------------------------------
// vbsp_ctrl
// Handshake controller: byte intake, sample transfer and the final report.
// -----------------------------------------------------------------------------
module vbsp_ctrl import vbsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       out_kind_o,
  output logic       out_sample_ld_o,
  input  vbsp_stat_t stat_i,
  output vbsp_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSmp  = 3'd1;  // never entered: no transition leads here
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StRep  = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       okind_q, okind_d;
  logic       take, free;

  // Output register is free when empty or being drained this cycle.
  // After the report every byte is taken and dropped.
  assign free = !ovalid_q || !out_stall_i;
  assign in_stall_o = !((state_q == StIdle && free) || state_q == StDone);
  assign take = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;  ovalid_d = ovalid_q && out_stall_i;  okind_d = okind_q;
    cmd_o = '0;  out_sample_ld_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (take) begin
          cmd_o.step = 1'b1;
          if (stat_i.active && stat_i.emit) begin
            ovalid_d = 1'b1;  okind_d = 1'b0;  out_sample_ld_o = 1'b1;
          end
          if (stat_i.finish) begin
            cmd_o.rep_start = 1'b1;
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) state_d = StMul;
      end
      StMul: begin
        cmd_o.mul_step = 1'b1;
        state_d = StRep;
      end
      StRep: begin
        if (free) begin
          ovalid_d = 1'b1;  okind_d = 1'b1;  state_d = StDone;
        end
      end
      StDone, StSmp: ;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;  ovalid_q <= 1'b0;  okind_q <= 1'b0;
    end else begin
      state_q <= state_d;  ovalid_q <= ovalid_d;  okind_q <= okind_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_kind_o  = okind_q;

  // A stalled result stays valid and keeps its kind
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_kind_o))
    else $error("result changed while stalled");
  // No byte is taken while report arithmetic runs
  a_nobusy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv || state_q == StMul) |-> in_stall_o)
    else $error("byte taken during report");
  // The report is the final transfer
  a_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDone |=> state_q == StDone)
    else $error("left done state");

endmodule
